>>> rtl/hwcm_pkg.sv
// Shared types, widths and register codes of the homography coordinate map.
`timescale 1ns / 1ps
package hwcm_pkg;

    localparam int COEF_W  = 32;   // Q16.16 coefficient width
    localparam int PIX_W   = 10;   // pixel coordinate width
    localparam int DELTA_W = PIX_W + 1;
    localparam int PROD_W  = COEF_W + DELTA_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int MAG_W   = SUM_W - 1;
    localparam int LIM_W   = MAG_W + PIX_W + 1;
    localparam int NUM_REGS = 8;
    localparam int IDX_W   = 3;

    localparam int DEF_AXIS_OFFSET = 52;
    localparam int DEF_SRC_WIDTH   = 320;
    localparam int DEF_SRC_HEIGHT  = 240;

    localparam logic signed [COEF_W-1:0] Q16_ONE = 32'sd65536;

    localparam logic [IDX_W-1:0] REG_UX = 3'd0;
    localparam logic [IDX_W-1:0] REG_UY = 3'd1;
    localparam logic [IDX_W-1:0] REG_UC = 3'd2;
    localparam logic [IDX_W-1:0] REG_VX = 3'd3;
    localparam logic [IDX_W-1:0] REG_VY = 3'd4;
    localparam logic [IDX_W-1:0] REG_VC = 3'd5;
    localparam logic [IDX_W-1:0] REG_WX = 3'd6;
    localparam logic [IDX_W-1:0] REG_WY = 3'd7;

    typedef struct packed {
        logic signed [COEF_W-1:0] ux;
        logic signed [COEF_W-1:0] uy;
        logic signed [COEF_W-1:0] uc;
        logic signed [COEF_W-1:0] vx;
        logic signed [COEF_W-1:0] vy;
        logic signed [COEF_W-1:0] vc;
        logic signed [COEF_W-1:0] wx;
        logic signed [COEF_W-1:0] wy;
    } t_coefs;

    // State carried through the divider stages.
    typedef struct packed {
        logic [MAG_W-1:0] rem_u;
        logic [MAG_W-1:0] rem_v;
        logic [MAG_W-1:0] den;
        logic [PIX_W-1:0] q_u;
        logic [PIX_W-1:0] q_v;
        logic             in_src;
        logic             axis;
    } t_div;

endpackage

>>> rtl/hwcm_map.sv
// Offset, homography products and sums, sign normalisation and bounds test.
`timescale 1ns / 1ps
module hwcm_map #(
    parameter int AXIS_OFFSET = hwcm_pkg::DEF_AXIS_OFFSET,
    parameter int SRC_WIDTH   = hwcm_pkg::DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT  = hwcm_pkg::DEF_SRC_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [hwcm_pkg::PIX_W-1:0]     i_col,
    input  logic [hwcm_pkg::PIX_W-1:0]     i_row,
    input  hwcm_pkg::t_coefs               i_coefs,
    output logic                           o_valid,
    output hwcm_pkg::t_div                 o_div
);
    import hwcm_pkg::*;

    // Stage 1: offsets.
    logic                      r_v1;
    logic signed [DELTA_W-1:0] r_dx, r_dy;
    logic                      r_axis1;
    // Stage 2: products.
    logic                      r_v2;
    logic signed [PROD_W-1:0]  r_pux, r_puy, r_pvx, r_pvy, r_pwx, r_pwy;
    logic signed [COEF_W-1:0]  r_uc2, r_vc2;
    logic                      r_axis2;
    // Stage 3: sums.
    logic                      r_v3;
    logic signed [SUM_W-1:0]   r_nu, r_nv, r_w;
    logic                      r_axis3;
    // Stage 4: sign normalised.
    logic                      r_v4;
    logic signed [SUM_W-1:0]   r_nu4, r_nv4, r_den4;
    logic                      r_wnz4, r_axis4;
    // Stage 5: bounds test.
    logic                      r_v5;
    t_div                      r_div;

    logic [LIM_W-1:0] n_lim_u, n_lim_v, n_nu_x, n_nv_x;

    assign n_lim_u = LIM_W'(r_den4[MAG_W-1:0]) * LIM_W'(SRC_WIDTH);
    assign n_lim_v = LIM_W'(r_den4[MAG_W-1:0]) * LIM_W'(SRC_HEIGHT);
    assign n_nu_x  = LIM_W'(r_nu4[MAG_W-1:0]);
    assign n_nv_x  = LIM_W'(r_nv4[MAG_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx    <= $signed({1'b0, i_col}) - $signed(DELTA_W'(AXIS_OFFSET));
            r_dy    <= $signed({1'b0, i_row}) - $signed(DELTA_W'(AXIS_OFFSET));
            r_axis1 <= (i_col == PIX_W'(AXIS_OFFSET)) || (i_row == PIX_W'(AXIS_OFFSET));

            r_pux   <= i_coefs.ux * r_dx;
            r_puy   <= i_coefs.uy * r_dy;
            r_pvx   <= i_coefs.vx * r_dx;
            r_pvy   <= i_coefs.vy * r_dy;
            r_pwx   <= i_coefs.wx * r_dx;
            r_pwy   <= i_coefs.wy * r_dy;
            r_uc2   <= i_coefs.uc;
            r_vc2   <= i_coefs.vc;
            r_axis2 <= r_axis1;

            r_nu    <= SUM_W'(r_pux) + SUM_W'(r_puy) + SUM_W'(r_uc2);
            r_nv    <= SUM_W'(r_pvx) + SUM_W'(r_pvy) + SUM_W'(r_vc2);
            r_w     <= SUM_W'(r_pwx) + SUM_W'(r_pwy) + SUM_W'(Q16_ONE);
            r_axis3 <= r_axis2;

            // A negative denominator flips all three signs together.
            if (r_w[SUM_W-1]) begin
                r_nu4  <= -r_nu;
                r_nv4  <= -r_nv;
                r_den4 <= -r_w;
            end else begin
                r_nu4  <= r_nu;
                r_nv4  <= r_nv;
                r_den4 <= r_w;
            end
            r_wnz4  <= (r_w != '0);
            r_axis4 <= r_axis3;

            r_div.rem_u  <= r_nu4[MAG_W-1:0];
            r_div.rem_v  <= r_nv4[MAG_W-1:0];
            r_div.den    <= r_den4[MAG_W-1:0];
            r_div.q_u    <= '0;
            r_div.q_v    <= '0;
            r_div.in_src <= r_wnz4 && (r_nu4 > 0) && (r_nv4 > 0)
                            && (n_nu_x < n_lim_u) && (n_nv_x < n_lim_v);
            r_div.axis   <= r_axis4;
        end
    end

    assign o_valid = r_v5;
    assign o_div   = r_div;

endmodule

>>> rtl/hwcm_div_step.sv
// One restoring division step for both source coordinates.
`timescale 1ns / 1ps
module hwcm_div_step #(
    parameter int SHIFT = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  hwcm_pkg::t_div  i_div,
    output logic            o_valid,
    output hwcm_pkg::t_div  o_div
);
    import hwcm_pkg::*;

    localparam int CMP_W = MAG_W + PIX_W;

    logic             r_valid;
    t_div             r_div;
    t_div             n_div;
    logic [CMP_W-1:0] n_sub, n_ru, n_rv;
    logic             n_ge_u, n_ge_v;

    assign n_sub  = CMP_W'(i_div.den) << SHIFT;
    assign n_ru   = CMP_W'(i_div.rem_u);
    assign n_rv   = CMP_W'(i_div.rem_v);
    assign n_ge_u = n_ru >= n_sub;
    assign n_ge_v = n_rv >= n_sub;

    always_comb begin
        n_div = i_div;
        if (n_ge_u) begin
            n_div.rem_u = MAG_W'(n_ru - n_sub);
            n_div.q_u   = i_div.q_u | (PIX_W'(1) << SHIFT);
        end
        if (n_ge_v) begin
            n_div.rem_v = MAG_W'(n_rv - n_sub);
            n_div.q_v   = i_div.q_v | (PIX_W'(1) << SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

>>> rtl/homography_warp_coord_map_top.sv
// Top level of the homography inverse-warp coordinate map.
`timescale 1ns / 1ps
// Each request on the slave stream carries one output pixel coordinate; the
// block subtracts the axis offset, applies the configured Q16.16 homography
// (third-row constant fixed at 1.0), divides exactly by the third component and
// returns the truncated source column and row with an inside flag and an axis
// overlay flag. One request is taken every clock cycle unless the pipeline is
// stalled, and each request passes through 15 register stages before its result
// is valid on the master side: five stages of offset, multiply, sum, sign
// normalisation and bounds test, then ten restoring division stages,
// one quotient bit each. Back-pressure on the master side stalls the whole
// pipeline, so the slave tready follows the master tready whenever the output
// register is occupied. A zero denominator and any point not strictly inside
// the source image give inside 0 and coordinates 0. The user writes the
// coefficients through the plain register port while the stream is idle, unenforced.
module homography_warp_coord_map_top #(
    parameter int AXIS_OFFSET = hwcm_pkg::DEF_AXIS_OFFSET,
    parameter int SRC_WIDTH   = hwcm_pkg::DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT  = hwcm_pkg::DEF_SRC_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [hwcm_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [hwcm_pkg::COEF_W-1:0]   i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // out_col, out_row, zero pad
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,  // src_col, src_row, zero pad
    output logic [1:0]                    m_axis_tuser   // inside_res, axis_mark
);
    import hwcm_pkg::*;

    localparam int STEPS = PIX_W;

    t_coefs r_coefs;
    logic   n_en;
    logic   w_valid [STEPS+1];
    t_div   w_div   [STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.ux <= Q16_ONE;
            r_coefs.uy <= '0;
            r_coefs.uc <= '0;
            r_coefs.vx <= '0;
            r_coefs.vy <= Q16_ONE;
            r_coefs.vc <= '0;
            r_coefs.wx <= '0;
            r_coefs.wy <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_UX: r_coefs.ux <= i_cfg_data;
                REG_UY: r_coefs.uy <= i_cfg_data;
                REG_UC: r_coefs.uc <= i_cfg_data;
                REG_VX: r_coefs.vx <= i_cfg_data;
                REG_VY: r_coefs.vy <= i_cfg_data;
                REG_VC: r_coefs.vc <= i_cfg_data;
                REG_WX: r_coefs.wx <= i_cfg_data;
                REG_WY: r_coefs.wy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output register is free or drained.
    assign n_en          = m_axis_tready || !w_valid[STEPS];
    assign s_axis_tready = n_en;

    hwcm_map #(
        .AXIS_OFFSET (AXIS_OFFSET),
        .SRC_WIDTH   (SRC_WIDTH),
        .SRC_HEIGHT  (SRC_HEIGHT)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (s_axis_tvalid),
        .i_col   (s_axis_tdata[PIX_W-1:0]),
        .i_row   (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .i_coefs (r_coefs),
        .o_valid (w_valid[0]),
        .o_div   (w_div[0])
    );

    // Quotient bits from the most significant down.
    for (genvar g = 0; g < STEPS; g++) begin : g_div
        hwcm_div_step #(
            .SHIFT (STEPS - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (n_en),
            .i_valid (w_valid[g]),
            .i_div   (w_div[g]),
            .o_valid (w_valid[g+1]),
            .o_div   (w_div[g+1])
        );
    end

    assign m_axis_tvalid = w_valid[STEPS];
    assign m_axis_tdata  = {4'b0000,
                            w_div[STEPS].in_src ? w_div[STEPS].q_v : {PIX_W{1'b0}},
                            w_div[STEPS].in_src ? w_div[STEPS].q_u : {PIX_W{1'b0}}};
    assign m_axis_tuser  = {w_div[STEPS].axis, w_div[STEPS].in_src};

endmodule

>>> test/tb_homography_warp_coord_map_top.sv
// Self-checking testbench for the homography inverse-warp coordinate map.
`timescale 1ns / 1ps
module tb_homography_warp_coord_map_top;
    import hwcm_pkg::*;

    localparam int AXIS   = 52;
    localparam int SW     = 320;
    localparam int SH     = 240;
    localparam int LATENCY = 15;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [9:0] col;
        logic [9:0] row;
        logic       hit;
        logic       axis;
    } t_map;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [COEF_W-1:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Predictor copy of the coefficient registers.
    logic signed [31:0] coefs [NUM_REGS];
    t_map  expected_maps [$];
    int    mismatches = 0;
    int    results_seen = 0;
    int    requests_sent = 0;
    int    idle_cycles = 0;

    homography_warp_coord_map_top dut (.*);

    always #1 i_clk = ~i_clk;

    // Exact test 0 < num/den < lim with den > 0, giving the floor.
    function automatic bit ratio_in(longint num, longint den, longint lim,
                                    output longint q);
        q = 0;
        if (num <= 0 || num >= lim * den) return 1'b0;
        q = num / den;
        return 1'b1;
    endfunction

    function automatic t_map map_coord(logic [9:0] col, logic [9:0] row);
        longint dx, dy, nu, nv, w, qu, qv;
        t_map m;
        dx = longint'(col) - AXIS;
        dy = longint'(row) - AXIS;
        nu = longint'(coefs[REG_UX]) * dx + longint'(coefs[REG_UY]) * dy
             + longint'(coefs[REG_UC]);
        nv = longint'(coefs[REG_VX]) * dx + longint'(coefs[REG_VY]) * dy
             + longint'(coefs[REG_VC]);
        w  = longint'(coefs[REG_WX]) * dx + longint'(coefs[REG_WY]) * dy + 65536;
        m = '0;
        if (w != 0) begin
            if (w < 0) begin
                w = -w; nu = -nu; nv = -nv;
            end
            m.hit = ratio_in(nu, w, SW, qu) && ratio_in(nv, w, SH, qv);
        end
        if (m.hit) begin
            m.col = qu[9:0];
            m.row = qv[9:0];
        end
        m.axis = (col == AXIS) || (row == AXIS);
        return m;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %0d, expected %0d (result %0d)",
                 what, got, want, results_seen);
    endtask

    task automatic write_coef(logic [IDX_W-1:0] idx, logic [31:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx < NUM_REGS) coefs[idx] = value;
        @(posedge i_clk);
    endtask

    // Sends one request after a random gap; the prediction is queued on accept.
    task automatic send_coord(logic [9:0] col, logic [9:0] row);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 1)) gap = 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, row, col};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_maps.push_back(map_coord(col, row));
        requests_sent++;
    endtask

    // Waits for the pipeline to drain before any register write.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_maps.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // Receiver: random stalls per result, with stall-free stretches.
    initial begin
        int wait_n;
        forever begin
            wait_n = ($urandom_range(0, 7) < 3) ? 0 : $urandom_range(0, 12);
            if (wait_n != 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && i_rst_n));
        end
    end

    // Result checker, field by field against the oldest prediction.
    always @(posedge i_clk) begin
        t_map want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_maps.size() == 0) begin
                report("unexpected result", 32'(m_axis_tdata), 32'd0);
            end else begin
                want = expected_maps.pop_front();
                if (m_axis_tdata[9:0] !== want.col)
                    report("src_col", 32'(m_axis_tdata[9:0]), 32'(want.col));
                if (m_axis_tdata[19:10] !== want.row)
                    report("src_row", 32'(m_axis_tdata[19:10]), 32'(want.row));
                if (m_axis_tuser[0] !== want.hit)
                    report("inside_res", 32'(m_axis_tuser[0]), 32'(want.hit));
                if (m_axis_tuser[1] !== want.axis)
                    report("axis_mark", 32'(m_axis_tuser[1]), 32'(want.axis));
            end
        end
    end

    // Watchdog on cycles with no request or result accepted.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Identity map: field extremes, axis rows and columns, borders.
    task automatic test_identity_extremes();
        send_coord(10'd0, 10'd0);
        send_coord(10'd1023, 10'd1023);
        send_coord(10'd52, 10'd100);
        send_coord(10'd100, 10'd52);
        send_coord(10'd52, 10'd52);
        send_coord(10'd53, 10'd53);
        send_coord(10'd371, 10'd291);
        send_coord(10'd372, 10'd292);
        send_coord(10'd371, 10'd292);
        send_coord(10'h2AA, 10'h155);
        send_coord(10'h155, 10'h2AA);
        drain();
    endtask

    // Zero and negative denominators, and half-scale fractional ratios.
    task automatic test_denominators();
        write_coef(REG_WX, 32'shFFFF_F000);   // w = 1 - dx/16: zero at dx = 16
        write_coef(REG_UC, 32'sd65536 * 10);
        send_coord(10'd68, 10'd60);           // zero denominator
        send_coord(10'd80, 10'd60);           // negative denominator
        send_coord(10'd100, 10'd90);
        send_coord(10'd60, 10'd70);
        drain();
        write_coef(REG_WX, 32'sh0000_8000);
        write_coef(REG_WY, 32'sh8000_0000);   // most negative coefficient
        send_coord(10'd53, 10'd52);
        send_coord(10'd1023, 10'd0);
        send_coord(10'd0, 10'd1023);
        drain();
    endtask

    task automatic random_coefs(int scale);
        for (int i = 0; i < NUM_REGS; i++) begin
            logic [31:0] v;
            v = $urandom;
            if (scale == 0) v = {{16{v[15]}}, v[15:0]};
            else if (scale == 1) v = {{12{v[19]}}, v[19:0]};
            write_coef(i[IDX_W-1:0], v);
        end
    endtask

    // Random phases: warps near identity, random coefficients at three scales, extremes.
    task automatic test_random_warps();
        for (int phase = 0; phase < 10; phase++) begin
            case (phase % 5)
                0: begin
                    write_coef(REG_UX, 32'sd65536 + $urandom_range(0, 8191) - 4096);
                    write_coef(REG_UY, $urandom_range(0, 8191) - 4096);
                    write_coef(REG_UC, $urandom_range(0, 120 << 16));
                    write_coef(REG_VX, $urandom_range(0, 8191) - 4096);
                    write_coef(REG_VY, 32'sd65536 + $urandom_range(0, 8191) - 4096);
                    write_coef(REG_VC, $urandom_range(0, 90 << 16));
                    write_coef(REG_WX, $urandom_range(0, 255) - 128);
                    write_coef(REG_WY, $urandom_range(0, 255) - 128);
                end
                1: random_coefs(0);
                2: random_coefs(1);
                3: random_coefs(2);
                default: begin
                    for (int i = 0; i < NUM_REGS; i++)
                        write_coef(i[IDX_W-1:0], $urandom_range(0, 1) ? 32'h7FFF_FFFF
                                                                    : 32'h8000_0000);
                end
            endcase
            for (int k = 0; k < 82; k++)
                send_coord($urandom_range(0, 1023), $urandom_range(0, 1023));
            drain();
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_REGS; i++) coefs[i] = 0;
        coefs[REG_UX] = Q16_ONE;
        coefs[REG_VY] = Q16_ONE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_identity_extremes();
        test_denominators();
        test_random_warps();
        drain();
        $display("Covered %0d coordinate requests and %0d results", requests_sent, results_seen);
        $display("over identity, singular, negative-denominator and random warps.");
        if (mismatches == 0 && expected_maps.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
